@@ rtl/msta_pkg.sv @@
// ----------------------------------------------------------------------------
// msta_pkg
// Shared types and operation codes for the metric statistics table.
// ----------------------------------------------------------------------------
package msta_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 3;
    localparam int IDX_W  = 6;

    // Operation codes carried in the input tuser field.
    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_AVG   = 3'd1;
    localparam logic [OP_W-1:0] OP_MAX   = 3'd2;
    localparam logic [OP_W-1:0] OP_MIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    // One table entry; value sits in the low half so it packs straight onto tdata.
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] value;
    } entry_t;

    // Operands of one running-average update.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] sample;
    } avg_req_t;

endpackage

@@ rtl/metric_statistics_table.sv @@
// ----------------------------------------------------------------------------
// metric_statistics_table: one result beat per input beat, one item at a time.
// Add, maximum, minimum, read and an average of a zero sample pass through
// the READ, EXEC and WRITE states; any other average also waits in AVG
// for the multiply and the bit-serial divider.
// Clear all is followed by a sweep that zeroes one entry a cycle.
// After reset the table is swept to zero, tready low.
// ----------------------------------------------------------------------------
module metric_statistics_table
#(
    parameter int NUM_ENTRIES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [5:0] metric_index, [69:6] sample_value, rest zero
    input  logic [2:0]   s_tuser,   // [2:0] opcode

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] entry_value, [127:64] entry_count
);

    localparam int DW     = msta_pkg::DATA_W;
    localparam int IW     = msta_pkg::IDX_W;
    localparam int ADDR_W = $clog2(NUM_ENTRIES);

    // Main sequencer. Every item goes through READ (memory address presented),
    // EXEC (read data back, result formed) and WRITE (write back and hand the
    // result to the output register). Because write back completes before
    // the next beat is accepted, a following access to the same entry always
    // sees the updated contents and no forwarding path is needed.
    typedef enum logic [5:0] {
        ST_SWEEP = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EXEC  = 6'b001000,
        ST_AVG   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    sweep_cnt_reg;
    logic                 m_valid_reg;

    // Captured input beat.
    logic [2:0]           op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [DW-1:0]        sample_reg;
    logic                 hit_reg;

    // Statistics memory: one 128-bit word per entry, registered read port.
    msta_pkg::entry_t     mem [NUM_ENTRIES];
    msta_pkg::entry_t     rd_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    msta_pkg::entry_t     mem_wdata;

    msta_pkg::entry_t     res_reg, exec_res;
    logic [127:0]         m_data_reg;

    logic                 accept, out_free, out_load, is_update;
    logic [IW-1:0]        in_idx;
    logic                 in_hit;

    msta_pkg::avg_req_t   avg_req;
    msta_pkg::entry_t     avg_rsp;
    logic                 avg_start, avg_busy, avg_done;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == ST_WRITE) && out_free;

    // An index beyond the table updates no entry and reports zeros; a clear still sweeps.
    assign in_idx = s_tdata[IW-1:0];
    assign in_hit = ({{(32-IW){1'b0}}, in_idx} < 32'(NUM_ENTRIES));

    // Only add, average, maximum and minimum write the entry back; unused
    // opcodes behave as a read.
    assign is_update = (op_reg == msta_pkg::OP_ADD) || (op_reg == msta_pkg::OP_AVG) ||
                       (op_reg == msta_pkg::OP_MAX) || (op_reg == msta_pkg::OP_MIN);

    // A zero sample leaves an average untouched, so the divider is skipped.
    assign avg_start = (state_reg == ST_EXEC) && hit_reg &&
                       (op_reg == msta_pkg::OP_AVG) && (sample_reg != '0);

    assign avg_req.value  = rd_reg.value;
    assign avg_req.count  = rd_reg.count;
    assign avg_req.sample = sample_reg;

    msta_avg_unit u_avg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (avg_start),
        .req   (avg_req),
        .busy  (avg_busy),
        .done  (avg_done),
        .rsp   (avg_rsp)
    );

    // Combinational operations on the entry just read. Minimum treats a stored
    // zero as an empty entry; maximum and minimum ignore a zero sample.
    always_comb
    begin
        exec_res = rd_reg;
        case (op_reg)
            msta_pkg::OP_ADD:
                exec_res.value = rd_reg.value + sample_reg;
            msta_pkg::OP_MAX:
                if (sample_reg != '0 && rd_reg.value < sample_reg)
                    exec_res.value = sample_reg;
            msta_pkg::OP_MIN:
                if (sample_reg != '0 && (rd_reg.value == '0 || rd_reg.value > sample_reg))
                    exec_res.value = sample_reg;
            default: ;
        endcase
        if (!hit_reg || op_reg == msta_pkg::OP_CLEAR)
            exec_res = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
                if (sweep_cnt_reg == ADDR_W'(NUM_ENTRIES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_EXEC;
            ST_EXEC:
                state_next = avg_start ? ST_AVG : ST_WRITE;
            ST_AVG:
                if (avg_done)
                    state_next = ST_WRITE;
            ST_WRITE:
                if (out_free)
                    state_next = (op_reg == msta_pkg::OP_CLEAR) ? ST_SWEEP : ST_IDLE;
            default:
                state_next = ST_SWEEP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            else
                sweep_cnt_reg <= '0;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser;
            addr_reg   <= ADDR_W'(in_idx);
            sample_reg <= s_tdata[IW+DW-1:IW];
            hit_reg    <= in_hit;
        end
        if (state_reg == ST_EXEC)
            res_reg <= exec_res;
        else if (state_reg == ST_AVG && avg_done)
            res_reg <= avg_rsp;
        if (out_load)
            m_data_reg <= res_reg;
    end

    // Write port: the zeroing sweep after reset or clear, otherwise write back.
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = out_load && hit_reg && is_update;
            mem_waddr = addr_reg;
            mem_wdata = res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[addr_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The table takes one beat at a time: no second beat right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input beat accepted while the previous item is in flight");

    // Write back never happens while the divider still works on the entry.
    a_no_write_in_avg: assert property (@(posedge clk) disable iff (!rst_n)
        avg_busy |-> !mem_we)
        else $error("memory written while the average unit is busy");

    // The divider reports only while the sequencer waits for it.
    a_avg_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        avg_done |-> (state_reg == ST_AVG))
        else $error("average result returned outside the wait state");

    // A clear reports zeros and is followed by a sweep of the table.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && op_reg == msta_pkg::OP_CLEAR) |=>
            (m_tdata == '0) && (state_reg == ST_SWEEP))
        else $error("clear did not report zeros or start the sweep");

endmodule

@@ rtl/msta_avg_unit.sv @@
// ----------------------------------------------------------------------------
// msta_avg_unit
// Running-average update: (value*count + sample) / (count + 1), wrapping at
// 64 bits, with a shared 32x32 multiplier and a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module msta_avg_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  msta_pkg::avg_req_t req,
    output logic              busy,
    output logic              done,
    output msta_pkg::entry_t  rsp
);

    localparam int DW     = msta_pkg::DATA_W;
    localparam int HW     = DW / 2;
    localparam int STEP_W = $clog2(DW);

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_MUL0 = 6'b000010,
        A_MUL1 = 6'b000100,
        A_MUL2 = 6'b001000,
        A_SUM  = 6'b010000,
        A_DIV  = 6'b100000
    } avg_state_t;

    avg_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;

    logic [DW-1:0]     val_reg, cnt_reg, smp_reg, den_reg;
    logic [DW-1:0]     prod_reg, acc_reg, quot_reg, rem_reg;

    logic [HW-1:0]     mul_a, mul_b;
    logic [DW-1:0]     mul_p;
    logic [DW:0]       rem_sh, den_ext;
    logic              take;

    // Low 64 bits of value*count only need three of the four partial products.
    always_comb
    begin
        case (state_reg)
            A_MUL1:
            begin
                mul_a = val_reg[HW-1:0];
                mul_b = cnt_reg[DW-1:HW];
            end
            A_MUL2:
            begin
                mul_a = val_reg[DW-1:HW];
                mul_b = cnt_reg[HW-1:0];
            end
            default:
            begin
                mul_a = val_reg[HW-1:0];
                mul_b = cnt_reg[HW-1:0];
            end
        endcase
    end

    // Full 64-bit product of the two unsigned 32-bit halves.
    assign mul_p = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};

    // Restoring division step. A zero divisor accepts every step, so the
    // quotient comes out all ones as required when the count wraps.
    assign rem_sh  = {rem_reg, quot_reg[DW-1]};
    assign den_ext = {1'b0, den_reg};
    assign take    = (rem_sh >= den_ext);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: if (start) state_next = A_MUL0;
            A_MUL0: state_next = A_MUL1;
            A_MUL1: state_next = A_MUL2;
            A_MUL2: state_next = A_SUM;
            A_SUM:  state_next = A_DIV;
            A_DIV:  if (step_reg == STEP_W'(DW - 1)) state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == A_DIV) && (step_reg == STEP_W'(DW - 1));
            if (state_reg == A_SUM)
                step_reg <= '0;
            else if (state_reg == A_DIV)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    val_reg <= req.value;
                    cnt_reg <= req.count;
                    smp_reg <= req.sample;
                    den_reg <= req.count + 1'b1;
                end
            end
            A_MUL1: acc_reg <= prod_reg;
            A_MUL2: acc_reg <= acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
            A_SUM:
            begin
                quot_reg <= acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}} + smp_reg;
                rem_reg  <= '0;
            end
            A_DIV:
            begin
                quot_reg <= {quot_reg[DW-2:0], take};
                rem_reg  <= take ? DW'(rem_sh - den_ext) : rem_sh[DW-1:0];
            end
            default: ;
        endcase
    end

    assign busy      = (state_reg != A_IDLE);
    assign done      = done_reg;
    assign rsp.value = quot_reg;
    assign rsp.count = den_reg;

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: metric statistics table
// Drives add, average, maximum, minimum, read and clear beats into the table
// under random source gaps and sink stalls. A local model of the table
// predicts each result beat, and a monitor compares every accepted result
// beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TBL_DEPTH = 64;

    // Codes 6 and 7 are unused by the table and behave as a read.
    localparam logic [msta_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [msta_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    // Cycles without any accepted beat before the run is declared hung.
    // The worst honest stretch is a long source gap, a long sink stall and a
    // clear or average in flight.
    localparam int HANG_LIMIT = 3000;

    // Quiet time after the last result: longer than a clear or an average.
    localparam int TAIL_CYCLES = 200;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata  = '0;    // [5:0] metric_index, [69:6] sample_value, rest zero
    logic [2:0]   s_tuser  = '0;    // [2:0] opcode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [63:0] entry_value, [127:64] entry_count

    // Shadow copy of the table, updated as each input beat is accepted.
    logic [msta_pkg::DATA_W-1:0] shadow_value [TBL_DEPTH];
    logic [msta_pkg::DATA_W-1:0] shadow_count [TBL_DEPTH];
    bit                          shadow_valid [TBL_DEPTH];

    // Results predicted but not yet seen on the master side, oldest first.
    msta_pkg::entry_t pending_entries [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  idle_on        = 1'b1;     // random gaps and stalls enabled
    int  ready_hold     = 0;

    metric_statistics_table #(
        .NUM_ENTRIES (TBL_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------

    function automatic void wipe_shadow();
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            shadow_value[i] = '0;
            shadow_count[i] = '0;
            shadow_valid[i] = 1'b0;
        end
    endfunction

    // Applies one operation to the shadow table and returns the result beat.
    function automatic msta_pkg::entry_t predict_entry(logic [msta_pkg::OP_W-1:0] op,
                                                       logic [msta_pkg::IDX_W-1:0] idx,
                                                       logic [msta_pkg::DATA_W-1:0] smp);
        msta_pkg::entry_t            res;
        logic [msta_pkg::DATA_W-1:0] val;
        logic [msta_pkg::DATA_W-1:0] cnt;
        logic [msta_pkg::DATA_W-1:0] num;
        logic [msta_pkg::DATA_W-1:0] den;
        res = '0;
        if (op == msta_pkg::OP_CLEAR)
        begin
            wipe_shadow();
            return res;
        end
        // An entry never written reads as zero.
        val = shadow_valid[idx] ? shadow_value[idx] : '0;
        cnt = shadow_valid[idx] ? shadow_count[idx] : '0;
        case (op)
            msta_pkg::OP_ADD:
                val = val + smp;
            msta_pkg::OP_AVG:
                if (smp != '0)
                begin
                    // Product and sum wrap at 64 bits; a wrapped count of zero
                    // makes the divider return all ones.
                    num = val * cnt + smp;
                    den = cnt + 64'd1;
                    val = (den != '0) ? num / den : '1;
                    cnt = den;
                end
            msta_pkg::OP_MAX:
                if (smp != '0 && val < smp)
                    val = smp;
            msta_pkg::OP_MIN:
                // A stored zero means the entry is empty, so any sample wins.
                if (smp != '0 && (val == '0 || val > smp))
                    val = smp;
            default:
                ;
        endcase
        if (op == msta_pkg::OP_ADD || op == msta_pkg::OP_AVG ||
            op == msta_pkg::OP_MAX || op == msta_pkg::OP_MIN)
        begin
            shadow_value[idx] = val;
            shadow_count[idx] = cnt;
            shadow_valid[idx] = 1'b1;
        end
        res.value = val;
        res.count = cnt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted input beat, checks every accepted
    // result beat. Both happen in one process so the push for a beat can
    // never race the pop of an earlier result.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        msta_pkg::entry_t want;
        msta_pkg::entry_t got;
        bit               moved;
        moved = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            pending_entries.push_back(predict_entry(s_tuser, s_tdata[5:0], s_tdata[69:6]));
            moved = 1'b1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            moved = 1'b1;
            got   = msta_pkg::entry_t'(m_tdata);
            if (pending_entries.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, value %h count %h",
                         $time, got.value, got.count);
            end
            else
            begin
                want = pending_entries.pop_front();
                if (got.value !== want.value)
                begin
                    mismatch_count++;
                    $display("%0t: entry_value expected %h actual %h",
                             $time, want.value, got.value);
                end
                if (got.count !== want.count)
                begin
                    mismatch_count++;
                    $display("%0t: entry_count expected %h actual %h",
                             $time, want.count, got.count);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Hang detector.
    initial
    begin
        while (quiet_cycles < HANG_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    // Sink side: alternating runs of ready and stall while idling is enabled.
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else if (!idle_on)
            m_tready <= 1'b1;
        else if (m_tready)
        begin
            m_tready   <= 1'b0;
            ready_hold = gap_len();
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    function automatic logic [msta_pkg::DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 30)
            return msta_pkg::DATA_W'($urandom_range(1, 15));
        else if (r < 40)
            return '1;
        else if (r < 50)
            return 64'd1 << $urandom_range(0, 63);
        else if (r < 55)
            return '1 - msta_pkg::DATA_W'($urandom_range(1, 15));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [msta_pkg::OP_W-1:0] pick_update_op();
        case ($urandom_range(0, 4))
            0:       return msta_pkg::OP_ADD;
            1:       return msta_pkg::OP_MAX;
            2:       return msta_pkg::OP_MIN;
            default: return msta_pkg::OP_AVG;
        endcase
    endfunction

    // Presents one beat after an optional gap and returns at the edge where
    // it is taken, with tvalid still high so a following beat can go straight
    // out without a bubble.
    task automatic send_beat(input logic [msta_pkg::OP_W-1:0] op,
                             input logic [msta_pkg::IDX_W-1:0] idx,
                             input logic [msta_pkg::DATA_W-1:0] smp);
        int gap;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, smp, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Holds the source off until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_entries.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_empty_reads();
        send_beat(msta_pkg::OP_READ, 6'd0, '0);
        send_beat(msta_pkg::OP_READ, 6'd63, '1);
    endtask

    task automatic test_add();
        send_beat(msta_pkg::OP_ADD, 6'd0, '1);
        send_beat(msta_pkg::OP_ADD, 6'd0, 64'd1);        // wraps through zero
        send_beat(msta_pkg::OP_ADD, 6'd1, '0);           // zero increment still marks the entry
        send_beat(msta_pkg::OP_ADD, 6'd1, 64'h5555_5555_5555_5555);
    endtask

    task automatic test_average();
        send_beat(msta_pkg::OP_AVG, 6'd5, '0);           // zero sample is ignored
        send_beat(msta_pkg::OP_AVG, 6'd5, 64'd10);
        send_beat(msta_pkg::OP_AVG, 6'd5, 64'd21);
        send_beat(msta_pkg::OP_AVG, 6'd5, '1);           // product and sum wrap
        send_beat(msta_pkg::OP_AVG, 6'd42, '1);
    endtask

    task automatic test_max_min();
        send_beat(msta_pkg::OP_MAX, 6'd7, '0);
        send_beat(msta_pkg::OP_MAX, 6'd7, 64'd5);
        send_beat(msta_pkg::OP_MAX, 6'd7, 64'd3);
        send_beat(msta_pkg::OP_MAX, 6'd7, '1);
        send_beat(msta_pkg::OP_MIN, 6'd9, '0);           // empty entry stays empty
        send_beat(msta_pkg::OP_MIN, 6'd9, 64'd8);        // first sample is taken
        send_beat(msta_pkg::OP_MIN, 6'd9, 64'd12);
        send_beat(msta_pkg::OP_MIN, 6'd9, 64'd1);
    endtask

    task automatic test_spare_opcodes();
        send_beat(OP_SPARE6, 6'd5, '1);
        send_beat(OP_SPARE7, 6'd7, 64'd99);
    endtask

    task automatic test_clear();
        send_beat(msta_pkg::OP_CLEAR, 6'd63, '1);
        send_beat(msta_pkg::OP_READ, 6'd5, '0);
        send_beat(msta_pkg::OP_MIN, 6'd9, 64'd4);
    endtask

    // Runs of updates on one entry, each closed by a read, mixed with loose
    // beats of any kind; clears are kept rare so averages build up counts.
    task automatic run_random_mix(input int n_items);
        int                         sent;
        int                         burst;
        logic [msta_pkg::IDX_W-1:0] idx;
        logic [msta_pkg::OP_W-1:0]  op;
        sent = 0;
        while (sent < n_items)
        begin
            idx = msta_pkg::IDX_W'($urandom_range(0, 63));
            if ($urandom_range(0, 99) < 75)
            begin
                burst = $urandom_range(2, 8);
                op    = pick_update_op();
                repeat (burst)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_beat(pick_update_op(), idx, pick_sample());
                    else
                        send_beat(op, idx, pick_sample());
                end
                send_beat(msta_pkg::OP_READ, idx, pick_sample());
                sent += burst + 1;
            end
            else
            begin
                op = msta_pkg::OP_W'($urandom_range(0, 7));
                if (op == msta_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
                    op = msta_pkg::OP_READ;
                send_beat(op, idx, pick_sample());
                sent++;
            end
        end
    endtask

    task automatic test_random_with_stalls();
        idle_on = 1'b1;
        run_random_mix(250);
        // Let the pipeline run dry once, then carry on.
        drain_results();
        run_random_mix(250);
    endtask

    task automatic test_random_streaming();
        idle_on = 1'b0;
        run_random_mix(250);
        idle_on = 1'b1;
    endtask

    task automatic test_random_tail();
        run_random_mix(150);
    endtask

    initial
    begin
        wipe_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_add();
        test_average();
        test_max_min();
        test_spare_opcodes();
        test_clear();
        test_random_with_stalls();
        test_random_streaming();
        test_random_tail();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_entries.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
